@@ sv/grid_footprint_check_and_stamp_defines.svh @@
// Assertion helpers for the checker file.
`ifndef GRID_FOOTPRINT_CHECK_AND_STAMP_DEFINES_SVH
`define GRID_FOOTPRINT_CHECK_AND_STAMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfcs check failed");

// Consequent must hold in the cycle after the antecedent.
`define GFCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gfcs check failed");

`endif

@@ sv/gfcs_pkg.sv @@
package gfcs_pkg;

  localparam int CELL_W  = 3;
  localparam int OP_W    = 3;
  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;

  localparam logic [CELL_W-1:0] CELL_UNKNOWN   = 3'd0;
  localparam logic [CELL_W-1:0] CELL_FREE      = 3'd1;
  localparam logic [CELL_W-1:0] CELL_OBSTACLE  = 3'd2;
  localparam logic [CELL_W-1:0] CELL_ALLOCATED = 3'd3;
  localparam logic [CELL_W-1:0] CELL_CUT       = 3'd4;

  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_FREE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_OBST = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd3;
  localparam logic [OP_W-1:0] OP_PLACE    = 3'd4;

  localparam logic CFG_ROWS_IN_USE    = 1'b0;
  localparam logic CFG_COLUMNS_IN_USE = 1'b1;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic              accepted;
    logic              off_grid;
  } res_t;

endpackage

@@ sv/gfcs_cell_ram.sv @@
module gfcs_cell_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [gfcs_pkg::CELL_W-1:0] wdata,
  output logic [gfcs_pkg::CELL_W-1:0] rdata
);
  import gfcs_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ sv/gfcs_ctrl.sv @@
module gfcs_ctrl #(
  parameter int MAX_ROWS         = 64,
  parameter int MAX_COLUMNS      = 64,
  parameter int FOOTPRINT_RADIUS = 3,
  parameter int CUT_RADIUS       = 1,
  parameter int ADDR_W           = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gfcs_pkg::OP_W-1:0]    op,
  input  logic [gfcs_pkg::COORD_W-1:0] row,
  input  logic [gfcs_pkg::COORD_W-1:0] column,
  input  logic [gfcs_pkg::DIM_W-1:0]   used_rows,
  input  logic [gfcs_pkg::DIM_W-1:0]   used_columns,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_addr,
  output logic [gfcs_pkg::CELL_W-1:0]  mem_wdata,
  input  logic [gfcs_pkg::CELL_W-1:0]  mem_rdata,
  output logic                         res_valid,
  input  logic                         res_take,
  output gfcs_pkg::res_t               res
);
  import gfcs_pkg::*;

  localparam int SPAN  = 2 * FOOTPRINT_RADIUS + 1;
  localparam int OFF_W = $clog2(SPAN);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam logic [OFF_W-1:0]   LAST_OFF  = OFF_W'(SPAN - 1);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]  COLS_A    = ADDR_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0]   RAD7      = DIM_W'(FOOTPRINT_RADIUS);
  localparam logic [DIM_W:0]     RAD8      = (DIM_W + 1)'(FOOTPRINT_RADIUS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DECODE  = 3'd2;
  localparam logic [2:0] S_RDWAIT  = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_SCANEND = 3'd5;
  localparam logic [2:0] S_STAMP   = 3'd6;
  localparam logic [2:0] S_RESULT  = 3'd7;

  logic [2:0]         state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [OP_W-1:0]    op_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic [OFF_W-1:0]   dr;
  logic [OFF_W-1:0]   dc;
  logic               pend;
  logic               fail;
  res_t               res_q;

  logic               center_in;
  logic               fits;
  logic               scan_ok;
  logic [DIM_W-1:0]   cell_r;
  logic [DIM_W-1:0]   cell_c;
  logic [ADDR_W-1:0]  scan_addr;
  logic [ADDR_W-1:0]  center_addr;
  logic               cut_hit;
  logic               last_cell;

  assign center_in = (DIM_W'(row_q) < used_rows) && (DIM_W'(col_q) < used_columns);

  // The footprint fits when every edge lies in the grid; the center is then inside too.
  assign fits = (DIM_W'(row_q) >= RAD7) && (DIM_W'(col_q) >= RAD7) &&
                ((DIM_W + 1)'(row_q) + RAD8 < (DIM_W + 1)'(used_rows)) &&
                ((DIM_W + 1)'(col_q) + RAD8 < (DIM_W + 1)'(used_columns));

  // The last footprint cell arrives in the cycle after the scan.
  assign scan_ok = !fail && (mem_rdata != CELL_OBSTACLE);

  // Only used once the footprint fits, and then these never go below zero.
  assign cell_r      = DIM_W'(row_q) + DIM_W'(dr) - RAD7;
  assign cell_c      = DIM_W'(col_q) + DIM_W'(dc) - RAD7;
  assign scan_addr   = ADDR_W'(ADDR_W'(cell_r) * COLS_A + ADDR_W'(cell_c));
  assign center_addr = ADDR_W'(ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q));
  assign last_cell   = (dr == LAST_OFF) && (dc == LAST_OFF);

  always_comb begin
    int dist_r;
    int dist_c;
    dist_r  = (int'(dr) >= FOOTPRINT_RADIUS) ? int'(dr) - FOOTPRINT_RADIUS
                                              : FOOTPRINT_RADIUS - int'(dr);
    dist_c  = (int'(dc) >= FOOTPRINT_RADIUS) ? int'(dc) - FOOTPRINT_RADIUS
                                              : FOOTPRINT_RADIUS - int'(dc);
    cut_hit = (dist_r <= CUT_RADIUS) && (dist_c <= CUT_RADIUS);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = scan_addr;
    mem_wdata = CELL_UNKNOWN;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_DECODE: begin
        mem_addr  = center_addr;
        mem_we    = center_in && ((op_q == OP_SET_FREE) || (op_q == OP_SET_OBST));
        mem_wdata = (op_q == OP_SET_FREE) ? CELL_FREE : CELL_OBSTACLE;
      end
      S_STAMP: begin
        mem_we    = 1'b1;
        mem_wdata = cut_hit ? CELL_CUT : CELL_ALLOCATED;
      end
      default: begin
        mem_addr = scan_addr;
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op;
            row_q <= row;
            col_q <= column;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          dr   <= '0;
          dc   <= '0;
          pend <= 1'b0;
          fail <= 1'b0;
          case (op_q)
            OP_READ: begin
              res_q <= '{CELL_UNKNOWN, 1'b0, !center_in};
              state <= center_in ? S_RDWAIT : S_RESULT;
            end
            OP_SET_FREE, OP_SET_OBST: begin
              res_q <= '{CELL_UNKNOWN, center_in, !center_in};
              state <= S_RESULT;
            end
            OP_CHECK, OP_PLACE: begin
              res_q <= '0;
              state <= fits ? S_SCAN : S_RESULT;
            end
            default: begin
              res_q <= '0;
              state <= S_RESULT;
            end
          endcase
        end
        S_RDWAIT: begin
          res_q.cell_value <= mem_rdata;
          state            <= S_RESULT;
        end
        S_SCAN: begin
          // Data arrives in the cycle after its address; pend marks a footprint cell.
          pend <= 1'b1;
          if (pend && (mem_rdata == CELL_OBSTACLE)) begin
            fail <= 1'b1;
          end
          if (last_cell) begin
            state <= S_SCANEND;
          end
          if (dc == LAST_OFF) begin
            dc <= '0;
            dr <= dr + OFF_W'(1);
          end else begin
            dc <= dc + OFF_W'(1);
          end
        end
        S_SCANEND: begin
          dr <= '0;
          dc <= '0;
          if (scan_ok && (op_q == OP_PLACE)) begin
            state <= S_STAMP;
          end else begin
            state <= S_RESULT;
          end
          if (scan_ok && (op_q == OP_CHECK)) begin
            res_q.accepted <= 1'b1;
          end
        end
        S_STAMP: begin
          if (last_cell) begin
            res_q.accepted <= 1'b1;
            state          <= S_RESULT;
          end
          if (dc == LAST_OFF) begin
            dc <= '0;
            dr <= dr + OFF_W'(1);
          end else begin
            dc <= dc + OFF_W'(1);
          end
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/grid_footprint_check_and_stamp.sv @@
// Channel  Direction  Handshake                 Payload
// in       to block   in_valid / in_stall       op, row, column
// out      from block out_valid / out_stall     cell_value, accepted, off_grid
// cfg      to block   cfg_we                    cfg_index, cfg_data
//
// One item at a time through a single-port cell memory, one access per cycle:
// reads and writes need only the center cell, a check reads every footprint cell,
// and a place reads and then stamps every one, all on that port.
// After reset a clearing pass writes every cell unknown while in_stall stays high;
// configuration writes are taken throughout. A finished result waits in the
// output register, and the next item may be accepted meanwhile; its own result
// is held until the register frees up.
module grid_footprint_check_and_stamp #(
  parameter int MAX_ROWS         = 64,
  parameter int MAX_COLUMNS      = 64,
  parameter int FOOTPRINT_RADIUS = 3,
  parameter int CUT_RADIUS       = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gfcs_pkg::OP_W-1:0]    op,
  input  logic [gfcs_pkg::COORD_W-1:0] row,
  input  logic [gfcs_pkg::COORD_W-1:0] column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gfcs_pkg::CELL_W-1:0]  cell_value,
  output logic                         accepted,
  output logic                         off_grid,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gfcs_pkg::DIM_W-1:0]   cfg_data
);
  import gfcs_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [10:0] MAX_ROWS_W    = 11'(MAX_ROWS);
  localparam logic [10:0] MAX_COLUMNS_W = 11'(MAX_COLUMNS);

  logic [DIM_W-1:0]  rows_in_use;
  logic [DIM_W-1:0]  columns_in_use;
  logic [DIM_W-1:0]  used_rows;
  logic [DIM_W-1:0]  used_columns;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= 7'd64;
      columns_in_use <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE:    rows_in_use    <= cfg_data;
        CFG_COLUMNS_IN_USE: columns_in_use <= cfg_data;
        default:            rows_in_use    <= rows_in_use;
      endcase
    end
  end

  // Register values above the grid size saturate to it.
  assign used_rows    = (11'(rows_in_use) > MAX_ROWS_W) ? MAX_ROWS_W[DIM_W-1:0]
                                                        : rows_in_use;
  assign used_columns = (11'(columns_in_use) > MAX_COLUMNS_W) ? MAX_COLUMNS_W[DIM_W-1:0]
                                                              : columns_in_use;

  gfcs_ctrl #(
    .MAX_ROWS         (MAX_ROWS),
    .MAX_COLUMNS      (MAX_COLUMNS),
    .FOOTPRINT_RADIUS (FOOTPRINT_RADIUS),
    .CUT_RADIUS       (CUT_RADIUS),
    .ADDR_W           (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .row          (row),
    .column       (column),
    .used_rows    (used_rows),
    .used_columns (used_columns),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  gfcs_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      cell_value <= res.cell_value;
      accepted   <= res.accepted;
      off_grid   <= res.off_grid;
    end
  end

endmodule

@@ sv/gfcs_checker.sv @@
`include "grid_footprint_check_and_stamp_defines.svh"

module gfcs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gfcs_pkg::CELL_W-1:0]  cell_value,
  input logic                         accepted,
  input logic                         off_grid
);
  import gfcs_pkg::*;

  // A held result stays offered until it is taken.
  `GFCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // Items are worked one at a time, so a transfer in closes the input side.
  `GFCS_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // A result never reports both success and an addressing error.
  `GFCS_ASSERT_NOW(a_flags_exclusive, out_valid, !(accepted && off_grid))

  // A nonzero cell value only comes from a good read, which sets no flag.
  `GFCS_ASSERT_NOW(a_read_clean, out_valid && (cell_value != CELL_UNKNOWN),
                   !accepted && !off_grid && (cell_value <= CELL_CUT))

endmodule

bind grid_footprint_check_and_stamp gfcs_checker u_gfcs_checker (.*);

@@ test/grid_footprint_check_and_stamp_tb.sv @@
`timescale 1ns / 1ps

module grid_footprint_check_and_stamp_tb;
  import gfcs_pkg::*;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int FOOT_R       = 3;
  localparam int CUT_R        = 1;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 120;

  // Op codes the block decodes as no operation.
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  typedef enum logic {STEP_ITEM, STEP_CONFIG} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic [OP_W-1:0]   code;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic              sel;
    logic [DIM_W-1:0]  setting;
    bit                typed;
    res_t              want;
  } script_step_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  column;
  logic                out_valid;
  logic                out_stall;
  logic [CELL_W-1:0]   cell_value;
  logic                accepted;
  logic                off_grid;
  logic                cfg_we;
  logic                cfg_index;
  logic [DIM_W-1:0]    cfg_data;

  // Shadow copy of the grid and of the two size registers.
  logic [CELL_W-1:0]   grid_cells [0:GRID_ROWS-1][0:GRID_COLS-1];
  logic [DIM_W-1:0]    rows_setting;
  logic [DIM_W-1:0]    cols_setting;

  res_t                expected_results [$];
  res_t                oldest_result;
  script_step_t        grid_script [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  bit                  send_steady = 1'b0;
  bit                  recv_steady = 1'b0;
  bit                  long_hold_req = 1'b0;

  int phase_rows  [7] = '{64, 127, 1, 40, 0, 64, 64};
  int phase_cols  [7] = '{64, 127, 64, 23, 17, 1, 64};
  int phase_items [7] = '{190, 150, 25, 140, 15, 20, 110};

  grid_footprint_check_and_stamp u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .row          (row),
    .column       (column),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_value   (cell_value),
    .accepted     (accepted),
    .off_grid     (off_grid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int span(input logic [DIM_W-1:0] setting);
    return (setting > DIM_W'(GRID_ROWS)) ? GRID_ROWS : int'(setting);
  endfunction

  function automatic bit on_grid(input int r, input int c);
    return r >= 0 && c >= 0 && r < span(rows_setting) && c < span(cols_setting);
  endfunction

  function automatic bit footprint_fits(input int r0, input int c0);
    if (!on_grid(r0, c0)) return 1'b0;
    for (int dr = -FOOT_R; dr <= FOOT_R; dr++) begin
      for (int dc = -FOOT_R; dc <= FOOT_R; dc++) begin
        if (!on_grid(r0 + dr, c0 + dc)) return 1'b0;
        if (grid_cells[r0 + dr][c0 + dc] == CELL_OBSTACLE) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Applies one operation to the shadow grid and returns the result it gives.
  function automatic res_t apply_grid_op(input logic [OP_W-1:0] code,
                                         input logic [COORD_W-1:0] r,
                                         input logic [COORD_W-1:0] c);
    res_t res;
    int   ri;
    int   ci;
    bit   in_cut;
    res = '0;
    ri  = int'(r);
    ci  = int'(c);
    case (code)
      OP_READ: begin
        if (on_grid(ri, ci)) res.cell_value = grid_cells[ri][ci];
        else res.off_grid = 1'b1;
      end
      OP_SET_FREE, OP_SET_OBST: begin
        if (on_grid(ri, ci)) begin
          grid_cells[ri][ci] = (code == OP_SET_FREE) ? CELL_FREE : CELL_OBSTACLE;
          res.accepted = 1'b1;
        end else begin
          res.off_grid = 1'b1;
        end
      end
      OP_CHECK: res.accepted = footprint_fits(ri, ci);
      OP_PLACE: begin
        if (footprint_fits(ri, ci)) begin
          for (int dr = -FOOT_R; dr <= FOOT_R; dr++) begin
            for (int dc = -FOOT_R; dc <= FOOT_R; dc++) begin
              in_cut = dr >= -CUT_R && dr <= CUT_R && dc >= -CUT_R && dc <= CUT_R;
              grid_cells[ri + dr][ci + dc] = in_cut ? CELL_CUT : CELL_ALLOCATED;
            end
          end
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random waits, broken up by runs where a side never idles.
  function automatic int next_wait(inout bit steady);
    if ($urandom_range(0, 24) == 0) steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic void add_known(input logic [OP_W-1:0] code, input int r, input int c,
                                    input logic [CELL_W-1:0] cv, input logic acc,
                                    input logic oor);
    script_step_t step;
    step = '{STEP_ITEM, code, COORD_W'(r), COORD_W'(c), 1'b0, '0, 1'b1, res_t'({cv, acc, oor})};
    grid_script.insert(grid_script.size(), step);
  endfunction

  function automatic void add_item(input logic [OP_W-1:0] code, input int r, input int c);
    script_step_t step;
    step = '{STEP_ITEM, code, COORD_W'(r), COORD_W'(c), 1'b0, '0, 1'b0, res_t'('0)};
    grid_script.insert(grid_script.size(), step);
  endfunction

  function automatic void add_cfg(input logic sel, input int setting);
    script_step_t step;
    step = '{STEP_CONFIG, OP_READ, '0, '0, sel, DIM_W'(setting), 1'b0, res_t'('0)};
    grid_script.insert(grid_script.size(), step);
  endfunction

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Size registers only change with nothing in flight.
  task automatic write_dim(input logic sel, input logic [DIM_W-1:0] setting);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= setting;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_ROWS_IN_USE) rows_setting = setting;
    else cols_setting = setting;
  endtask

  task automatic send_grid_op(input logic [OP_W-1:0] code, input logic [COORD_W-1:0] r,
                              input logic [COORD_W-1:0] c, input bit typed,
                              input res_t typed_res);
    int   gap;
    res_t predicted;
    gap = next_wait(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    row      <= r;
    column   <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_grid_op(code, r, c);
    expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      hold = next_wait(recv_steady);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, %s %0d %0b %0b",
                 $time, "got cell_value accepted off_grid", cell_value, accepted,
                 off_grid);
      end else begin
        oldest_result = expected_results.pop_front();
        if (cell_value !== oldest_result.cell_value || accepted !== oldest_result.accepted ||
            off_grid !== oldest_result.off_grid) begin
          error_count++;
          $display("%0t ns: mismatch, expected cell_value %0d accepted %0b off_grid %0b,",
                   $time, oldest_result.cell_value, oldest_result.accepted,
                   oldest_result.off_grid);
          $display("%0t ns:   got cell_value %0d accepted %0b off_grid %0b",
                   $time, cell_value, accepted, off_grid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    int rr;
    int cc;
    int eff_r;
    int eff_c;
    int last_r;
    int last_c;
    logic [OP_W-1:0] code;

    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_READ;
    row       = '0;
    column    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ROWS_IN_USE;
    cfg_data  = '0;
    rows_setting = DIM_W'(GRID_ROWS);
    cols_setting = DIM_W'(GRID_COLS);
    last_r = 30;
    last_c = 30;
    for (int i = 0; i < GRID_ROWS; i++)
      for (int j = 0; j < GRID_COLS; j++) grid_cells[i][j] = CELL_UNKNOWN;

    add_known(OP_READ, 0, 0, CELL_UNKNOWN, 1'b0, 1'b0);
    add_known(OP_SET_FREE, 63, 63, CELL_UNKNOWN, 1'b1, 1'b0);
    add_known(OP_READ, 63, 63, CELL_FREE, 1'b0, 1'b0);
    add_known(OP_SET_OBST, 10, 10, CELL_UNKNOWN, 1'b1, 1'b0);
    add_known(OP_READ, 10, 10, CELL_OBSTACLE, 1'b0, 1'b0);
    // The obstacle sits on the top edge of this footprint, then just above the next one.
    add_known(OP_CHECK, 13, 10, CELL_UNKNOWN, 1'b0, 1'b0);
    add_known(OP_CHECK, 14, 10, CELL_UNKNOWN, 1'b1, 1'b0);
    add_known(OP_CHECK, 2, 20, CELL_UNKNOWN, 1'b0, 1'b0);
    add_known(OP_CHECK, 60, 60, CELL_UNKNOWN, 1'b1, 1'b0);
    add_known(OP_CHECK, 61, 60, CELL_UNKNOWN, 1'b0, 1'b0);
    add_known(OP_PLACE, 30, 30, CELL_UNKNOWN, 1'b1, 1'b0);
    add_known(OP_READ, 30, 30, CELL_CUT, 1'b0, 1'b0);
    add_known(OP_READ, 31, 29, CELL_CUT, 1'b0, 1'b0);
    add_known(OP_READ, 33, 27, CELL_ALLOCATED, 1'b0, 1'b0);
    add_known(OP_READ, 34, 30, CELL_UNKNOWN, 1'b0, 1'b0);
    add_known(OP_UNUSED_LO, 60, 5, CELL_UNKNOWN, 1'b0, 1'b0);
    add_item(OP_UNUSED_MID, 0, 63);
    add_known(OP_UNUSED_HI, 63, 63, CELL_UNKNOWN, 1'b0, 1'b0);
    add_item(OP_PLACE, 30, 30);
    // An empty grid rejects everything.
    add_cfg(CFG_ROWS_IN_USE, 0);
    add_known(OP_READ, 0, 0, CELL_UNKNOWN, 1'b0, 1'b1);
    add_known(OP_SET_OBST, 5, 5, CELL_UNKNOWN, 1'b0, 1'b1);
    add_known(OP_PLACE, 30, 30, CELL_UNKNOWN, 1'b0, 1'b0);
    // Oversized row count saturates; a narrow grid hides the stamped cells.
    add_cfg(CFG_ROWS_IN_USE, 127);
    add_cfg(CFG_COLUMNS_IN_USE, 8);
    add_known(OP_READ, 30, 30, CELL_UNKNOWN, 1'b0, 1'b1);
    add_known(OP_READ, 63, 7, CELL_UNKNOWN, 1'b0, 1'b0);
    add_item(OP_CHECK, 3, 4);
    add_item(OP_PLACE, 3, 4);
    add_cfg(CFG_COLUMNS_IN_USE, 64);
    add_known(OP_READ, 30, 30, CELL_CUT, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (grid_script[i]) begin
      if (grid_script[i].kind == STEP_CONFIG)
        write_dim(grid_script[i].sel, grid_script[i].setting);
      else
        send_grid_op(grid_script[i].code, grid_script[i].r, grid_script[i].c,
                     grid_script[i].typed, grid_script[i].want);
    end

    for (int p = 0; p < 7; p++) begin
      write_dim(CFG_ROWS_IN_USE, DIM_W'(phase_rows[p]));
      write_dim(CFG_COLUMNS_IN_USE, DIM_W'(phase_cols[p]));
      eff_r = span(rows_setting);
      eff_c = span(cols_setting);
      for (int k = 0; k < phase_items[p]; k++) begin
        if (p == 0 && k == 60) long_hold_req = 1'b1;
        if (p == 0 && k == 120) wait_for_results();
        pick = $urandom_range(0, 99);
        if (pick < 30) code = OP_READ;
        else if (pick < 45) code = OP_SET_FREE;
        else if (pick < 53) code = OP_SET_OBST;
        else if (pick < 72) code = OP_CHECK;
        else if (pick < 93) code = OP_PLACE;
        else code = OP_UNUSED_LO + OP_W'($urandom_range(0, 2));
        if (eff_r == 0 || eff_c == 0 || $urandom_range(0, 9) == 0) begin
          rr = $urandom_range(0, 63);
          cc = $urandom_range(0, 63);
        end else if (code == OP_READ && $urandom_range(0, 1) == 1) begin
          // Look around the latest footprint to see its cut and allocated cells.
          rr = last_r + int'($urandom_range(0, 8)) - 4;
          cc = last_c + int'($urandom_range(0, 8)) - 4;
          rr = (rr < 0) ? 0 : (rr > 63) ? 63 : rr;
          cc = (cc < 0) ? 0 : (cc > 63) ? 63 : cc;
        end else begin
          rr = $urandom_range(0, eff_r - 1);
          cc = $urandom_range(0, eff_c - 1);
        end
        if (code == OP_PLACE) begin
          last_r = rr;
          last_c = cc;
        end
        send_grid_op(code, COORD_W'(rr), COORD_W'(cc), 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
